>>> rtl/core/ean13_pkg.sv
// Shared types, segment indexes and code tables for the EAN-13 pattern encoder.
package ean13_pkg;

   localparam int NUM_DIGITS   = 12;
   localparam int NUM_SEGMENTS = 17;
   localparam int SEG_W        = $clog2(NUM_SEGMENTS);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [SEG_W-1:0] SEG_LEAD_QUIET  = SEG_W'(0);
   localparam logic [SEG_W-1:0] SEG_START_GUARD = SEG_W'(1);
   localparam logic [SEG_W-1:0] SEG_LEFT_FIRST  = SEG_W'(2);
   localparam logic [SEG_W-1:0] SEG_LEFT_LAST   = SEG_W'(7);
   localparam logic [SEG_W-1:0] SEG_CENTER      = SEG_W'(8);
   localparam logic [SEG_W-1:0] SEG_RIGHT_FIRST = SEG_W'(9);
   localparam logic [SEG_W-1:0] SEG_RIGHT_LAST  = SEG_W'(14);
   localparam logic [SEG_W-1:0] SEG_END_GUARD   = SEG_W'(15);
   localparam logic [SEG_W-1:0] SEG_TRAIL_QUIET = SEG_W'(16);

   localparam logic [8:0] PAT_QUIET  = 9'b000000000;
   localparam logic [8:0] PAT_GUARD  = 9'b000000101;
   localparam logic [8:0] PAT_CENTER = 9'b000001010;
   localparam logic [3:0] LEN_GUARD  = 4'd3;
   localparam logic [3:0] LEN_CENTER = 4'd5;
   localparam logic [3:0] LEN_DIGIT  = 4'd7;

   typedef struct packed {
      logic [NUM_DIGITS-1:0][3:0] digits;  // index = digit position, nibbles cleaned
      logic [7:0]                 sum;     // weighted 1/3 sum
   } entry_type;

   typedef struct packed {
      logic [3:0] check_digit;
      logic [3:0] length;
      logic [8:0] bits;
      logic       last;
   } segment_type;

   function automatic logic [6:0] l_code(input logic [3:0] d);
      case (d)
         4'd0: l_code = 7'b0001101;
         4'd1: l_code = 7'b0011001;
         4'd2: l_code = 7'b0010011;
         4'd3: l_code = 7'b0111101;
         4'd4: l_code = 7'b0100011;
         4'd5: l_code = 7'b0110001;
         4'd6: l_code = 7'b0101111;
         4'd7: l_code = 7'b0111011;
         4'd8: l_code = 7'b0110111;
         4'd9: l_code = 7'b0001011;
         default: l_code = 7'b0001101;
      endcase
   endfunction

   function automatic logic [6:0] g_code(input logic [3:0] d);
      case (d)
         4'd0: g_code = 7'b0100111;
         4'd1: g_code = 7'b0110011;
         4'd2: g_code = 7'b0011011;
         4'd3: g_code = 7'b0100001;
         4'd4: g_code = 7'b0011101;
         4'd5: g_code = 7'b0111001;
         4'd6: g_code = 7'b0000101;
         4'd7: g_code = 7'b0010001;
         4'd8: g_code = 7'b0001001;
         4'd9: g_code = 7'b0010111;
         default: g_code = 7'b0100111;
      endcase
   endfunction

   function automatic logic [6:0] r_code(input logic [3:0] d);
      case (d)
         4'd0: r_code = 7'b1110010;
         4'd1: r_code = 7'b1100110;
         4'd2: r_code = 7'b1101100;
         4'd3: r_code = 7'b1000010;
         4'd4: r_code = 7'b1011100;
         4'd5: r_code = 7'b1001110;
         4'd6: r_code = 7'b1010000;
         4'd7: r_code = 7'b1000100;
         4'd8: r_code = 7'b1001000;
         4'd9: r_code = 7'b1110100;
         default: r_code = 7'b1110010;
      endcase
   endfunction

   // bit 5 selects the code of the second digit, bit 0 that of the seventh; 1 = G
   function automatic logic [5:0] parity_word(input logic [3:0] d);
      case (d)
         4'd0: parity_word = 6'b000000;
         4'd1: parity_word = 6'b001011;
         4'd2: parity_word = 6'b001101;
         4'd3: parity_word = 6'b001110;
         4'd4: parity_word = 6'b010011;
         4'd5: parity_word = 6'b011001;
         4'd6: parity_word = 6'b011100;
         4'd7: parity_word = 6'b010101;
         4'd8: parity_word = 6'b010110;
         4'd9: parity_word = 6'b011010;
         default: parity_word = 6'b000000;
      endcase
   endfunction

endpackage

>>> rtl/core/ean13_front.sv
// Front end: takes a digit beat, cleans the nibbles and forms the weighted sum.
module ean13_front import ean13_pkg::*; (
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // digits
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic [NUM_DIGITS-1:0][3:0] clean;
   logic [7:0]                 acc;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         clean[i] = req_tdata[44-4*i +: 4];
         if (clean[i] > 4'd9) begin
            clean[i] = 4'd0;
         end
      end
      acc = 8'd0;
      for (int j = 0; j < NUM_DIGITS/2; j++) begin
         acc = acc + 8'(clean[2*j]) + 8'(clean[2*j+1]) + {3'd0, clean[2*j+1], 1'b0};
      end
   end

   assign req_tready        = !queue_full && !reset;
   assign push              = req_tvalid && req_tready;
   assign push_entry.digits = clean;
   assign push_entry.sum    = acc;

endmodule

>>> rtl/core/ean13_queue.sv
// Short queue between front and back end.
module ean13_queue import ean13_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

>>> rtl/core/ean13_back.sv
// Back end: walks the 17 segments of one code into a registered output stage.
module ean13_back import ean13_pkg::*; #(
   parameter int QUIET_MODULES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output segment_type out_segment
);

   logic                       busy_ff, busy_in;
   logic [SEG_W-1:0]           seg_ff, seg_in;
   logic [NUM_DIGITS-1:0][3:0] digs_ff, digs_in;
   logic [3:0]                 chk_ff, chk_in;
   logic                       out_valid_ff, out_valid_in;
   segment_type                out_ff, out_in;

   logic        advance, emit, finish;
   logic [3:0]  pos;
   logic [3:0]  digit;
   logic [5:0]  par;
   logic [2:0]  par_idx;
   segment_type seg_value;

   function automatic logic [3:0] check_of(input logic [7:0] sum);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  rem;
      prod = 16'(sum) * 16'd205;
      q    = prod[15:11];
      rem  = sum - 8'(q) * 8'd10;
      check_of = (rem == 8'd0) ? 4'd0 : 4'(8'd10 - rem);
   endfunction

   assign advance = !out_valid_ff || out_ready;
   assign emit    = busy_ff && advance;
   assign finish  = emit && (seg_ff == SEG_TRAIL_QUIET);
   assign pop     = (!busy_ff || finish) && head_valid;

   always_comb begin
      if (seg_ff <= SEG_LEFT_LAST) begin
         pos = 4'(seg_ff - SEG_LEFT_FIRST + SEG_W'(1));
      end else begin
         pos = 4'(seg_ff - SEG_RIGHT_FIRST + SEG_W'(7));
      end
      digit   = (pos >= 4'(NUM_DIGITS)) ? chk_ff : digs_ff[pos];
      par     = parity_word(digs_ff[0]);
      par_idx = 3'(4'd6 - pos);

      seg_value.check_digit = chk_ff;
      seg_value.last        = 1'b0;
      seg_value.length      = LEN_DIGIT;
      seg_value.bits        = PAT_QUIET;
      if (seg_ff == SEG_LEAD_QUIET || seg_ff == SEG_TRAIL_QUIET) begin
         seg_value.length = 4'(QUIET_MODULES);
         seg_value.last   = (seg_ff == SEG_TRAIL_QUIET);
      end else if (seg_ff == SEG_START_GUARD || seg_ff == SEG_END_GUARD) begin
         seg_value.bits   = PAT_GUARD;
         seg_value.length = LEN_GUARD;
      end else if (seg_ff == SEG_CENTER) begin
         seg_value.bits   = PAT_CENTER;
         seg_value.length = LEN_CENTER;
      end else if (seg_ff <= SEG_LEFT_LAST) begin
         seg_value.bits = {2'b00, par[par_idx] ? g_code(digit) : l_code(digit)};
      end else begin
         seg_value.bits = {2'b00, r_code(digit)};
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      seg_in       = seg_ff;
      digs_in      = digs_ff;
      chk_in       = chk_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pop) begin
         busy_in = 1'b1;
         seg_in  = SEG_LEAD_QUIET;
         digs_in = head_entry.digits;
         chk_in  = check_of(head_entry.sum);
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         seg_in = seg_ff + SEG_W'(1);
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = seg_value;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         seg_ff       <= SEG_LEAD_QUIET;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         seg_ff       <= seg_in;
         out_valid_ff <= out_valid_in;
      end
      digs_ff <= digs_in;
      chk_ff  <= chk_in;
      out_ff  <= out_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_segment = out_ff;

   a_seg_step: assert property (@(posedge clock) disable iff (reset)
      (emit && !finish) |=> (seg_ff == $past(seg_ff) + SEG_W'(1)))
      else $error("segment counter skipped");

   a_last_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last) |-> (out_ff.bits == PAT_QUIET))
      else $error("last segment is not a quiet zone");

   a_check_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.check_digit <= 4'd9))
      else $error("check digit out of range");

   a_busy_seg: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (seg_ff <= SEG_TRAIL_QUIET))
      else $error("segment counter out of range");

endmodule

>>> rtl/core/ean13_barcode_pattern_encoder_top.sv
// EAN-13 pattern encoder: one 12-digit beat in, 17 module-pattern segment beats out.
// Each code on req_tdata (first digit in bits 47..44, nibbles above 9 read as 0)
// gives 17 segment beats: quiet zone, start guard, six L/G digits, center guard,
// five R digits and the check digit, end guard, quiet zone (marked by rsp_tlast).
// The segment walker in the back end emits one segment per cycle while rsp_tready
// does not hold it, so a code occupies it for all 17 of its segments; a two-beat
// queue lets the next code be taken while the current one is still being walked.
// An accepted code passes the queue, the walker state and the output register.
module ean13_barcode_pattern_encoder_top import ean13_pkg::*; #(
   parameter int QUIET_MODULES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] digits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [8:0] segment_bits, [12:9] segment_length,
                                    // [16:13] check_digit, [23:17] zero
   output logic        rsp_tlast    // last
);

   logic        push, queue_full, head_valid, pop;
   entry_type   push_entry, head_entry;
   segment_type out_segment;

   ean13_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ean13_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   ean13_back #(
      .QUIET_MODULES (QUIET_MODULES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_segment (out_segment)
   );

   assign rsp_tdata = {7'd0, out_segment.check_digit, out_segment.length, out_segment.bits};
   assign rsp_tlast = out_segment.last;

endmodule
